### design/tcc_pkg.sv
// shared types and constants for the triangle circumcenter block
`timescale 1ns / 1ps
package tcc_pkg;
	localparam int OUT_BITS = 58;

	typedef struct packed {
		logic valid;
		logic col;
		logic neg_x;
		logic neg_y;
	} tcc_ctl_t;
endpackage

### design/triangle_circumcenter.sv
// triangle circumcenter top level: determinant, numerators and pipelined division
//
// usage:
// - input channel in_valid/in_stall carries one triangle per request
//   (ax, ay, bx, by_coord, cx, cy, signed coordinates)
// - output channel out_valid/out_stall returns center_x, center_y (signed,
//   FRAC_BITS fraction bits, rounded toward zero) and collinear
// - collinear triangles give collinear = 1 and both coordinates at -1.0
// - one request accepted per cycle while the output is not stalled; NMW =
//   3*COORD_BITS + 4 + FRAC_BITS is the divider depth (60 at defaults)
// - four arithmetic stages, one divider stage per quotient bit, one output register
// - the whole pipeline holds while the output is valid and stalled;
//   in_stall follows from that, no request is lost or repeated
// - reset clears all valid bits; the pipeline starts empty
`timescale 1ns / 1ps
module triangle_circumcenter #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by_coord,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [tcc_pkg::OUT_BITS-1:0] center_x,
	output logic signed [tcc_pkg::OUT_BITS-1:0] center_y,
	output logic                          collinear
);
	import tcc_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;
	localparam int SW  = 2 * CB + 1;
	localparam int PW  = 2 * CB + 1;
	localparam int DDW = 2 * CB + 4;
	localparam int NPW = 3 * CB + 2;
	localparam int NW  = 3 * CB + 4;
	localparam int NMW = NW + FRAC_BITS;
	localparam int DMW = DDW;
	localparam logic [OUT_BITS-1:0] NEG_ONE =
		OUT_BITS'(0) - (OUT_BITS'(1) << FRAC_BITS);

	logic en;
	logic out_valid_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// stage 1: coordinates and differences
	logic                 v_s1;
	logic signed [CB-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1;
	logic signed [DW-1:0] dy23_s1, dy31_s1, dy12_s1, dx32_s1, dx13_s1, dx21_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= ax;
			y1_s1   <= ay;
			x2_s1   <= bx;
			y2_s1   <= by_coord;
			x3_s1   <= cx;
			y3_s1   <= cy;
			dy23_s1 <= DW'(by_coord) - DW'(cy);
			dy31_s1 <= DW'(cy) - DW'(ay);
			dy12_s1 <= DW'(ay) - DW'(by_coord);
			dx32_s1 <= DW'(cx) - DW'(bx);
			dx13_s1 <= DW'(ax) - DW'(cx);
			dx21_s1 <= DW'(bx) - DW'(ax);
		end
	end

	// stage 2: squared norms and determinant products
	logic                 v_s2;
	logic signed [SW-1:0] sq1_s2, sq2_s2, sq3_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2;
	logic signed [DW-1:0] dy23_s2, dy31_s2, dy12_s2, dx32_s2, dx13_s2, dx21_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s2  <= SW'(x1_s1) * SW'(x1_s1) + SW'(y1_s1) * SW'(y1_s1);
			sq2_s2  <= SW'(x2_s1) * SW'(x2_s1) + SW'(y2_s1) * SW'(y2_s1);
			sq3_s2  <= SW'(x3_s1) * SW'(x3_s1) + SW'(y3_s1) * SW'(y3_s1);
			p1_s2   <= PW'(x1_s1) * PW'(dy23_s1);
			p2_s2   <= PW'(x2_s1) * PW'(dy31_s1);
			p3_s2   <= PW'(x3_s1) * PW'(dy12_s1);
			dy23_s2 <= dy23_s1;
			dy31_s2 <= dy31_s1;
			dy12_s2 <= dy12_s1;
			dx32_s2 <= dx32_s1;
			dx13_s2 <= dx13_s1;
			dx21_s2 <= dx21_s1;
		end
	end

	// stage 3: determinant and numerator products
	logic                  v_s3;
	logic signed [DDW-1:0] d_s3;
	logic signed [NPW-1:0] nx1_s3, nx2_s3, nx3_s3, ny1_s3, ny2_s3, ny3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3   <= (DDW'(p1_s2) + DDW'(p2_s2) + DDW'(p3_s2)) <<< 1;
			nx1_s3 <= NPW'(sq1_s2) * NPW'(dy23_s2);
			nx2_s3 <= NPW'(sq2_s2) * NPW'(dy31_s2);
			nx3_s3 <= NPW'(sq3_s2) * NPW'(dy12_s2);
			ny1_s3 <= NPW'(sq1_s2) * NPW'(dx32_s2);
			ny2_s3 <= NPW'(sq2_s2) * NPW'(dx13_s2);
			ny3_s3 <= NPW'(sq3_s2) * NPW'(dx21_s2);
		end
	end

	// stage 4: numerators, signs and magnitudes
	logic signed [NW-1:0] nx, ny;
	logic [NW-1:0]        nxm, nym;
	logic [DDW-1:0]       dm;

	always_comb begin
		nx  = NW'(nx1_s3) + NW'(nx2_s3) + NW'(nx3_s3);
		ny  = NW'(ny1_s3) + NW'(ny2_s3) + NW'(ny3_s3);
		nxm = nx[NW-1] ? NW'(-nx) : NW'(nx);
		nym = ny[NW-1] ? NW'(-ny) : NW'(ny);
		dm  = d_s3[DDW-1] ? DDW'(-d_s3) : DDW'(d_s3);
	end

	tcc_ctl_t       ctl_s4;
	logic [NMW-1:0] nmx_s4, nmy_s4;
	logic [DMW-1:0] dm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4.valid <= v_s3;
			ctl_s4.col   <= (d_s3 == '0);
			ctl_s4.neg_x <= nx[NW-1] ^ d_s3[DDW-1];
			ctl_s4.neg_y <= ny[NW-1] ^ d_s3[DDW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmx_s4 <= NMW'(nxm) << FRAC_BITS;
			nmy_s4 <= NMW'(nym) << FRAC_BITS;
			dm_s4  <= dm;
		end
	end

	// division
	tcc_ctl_t       ctl_dv;
	logic [NMW-1:0] qx_dv, qy_dv;

	tcc_div #(
		.NMW(NMW),
		.DMW(DMW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s4),
		.num_x   (nmx_s4),
		.num_y   (nmy_s4),
		.den     (dm_s4),
		.ctl_out (ctl_dv),
		.quot_x  (qx_dv),
		.quot_y  (qy_dv)
	);

	// output register
	logic [NMW+OUT_BITS-1:0] qx_ext, qy_ext;
	logic [OUT_BITS-1:0]     qx_t, qy_t;
	logic [OUT_BITS-1:0]     center_x_q, center_y_q;
	logic                    collinear_q;

	always_comb begin
		qx_ext = {{OUT_BITS{1'b0}}, qx_dv};
		qy_ext = {{OUT_BITS{1'b0}}, qy_dv};
		qx_t   = qx_ext[OUT_BITS-1:0];
		qy_t   = qy_ext[OUT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			collinear_q <= ctl_dv.col;
			if (ctl_dv.col) begin
				center_x_q <= NEG_ONE;
				center_y_q <= NEG_ONE;
			end else begin
				center_x_q <= ctl_dv.neg_x ? OUT_BITS'(0) - qx_t : qx_t;
				center_y_q <= ctl_dv.neg_y ? OUT_BITS'(0) - qy_t : qy_t;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = center_x_q;
	assign center_y  = center_y_q;
	assign collinear = collinear_q;
endmodule

### design/tcc_div.sv
// pipelined restoring divider, one quotient bit per stage, two numerators over one divisor
`timescale 1ns / 1ps
module tcc_div #(
	parameter int NMW = 60,
	parameter int DMW = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tcc_pkg::tcc_ctl_t  ctl_in,
	input  logic [NMW-1:0]      num_x,
	input  logic [NMW-1:0]      num_y,
	input  logic [DMW-1:0]      den,
	output tcc_pkg::tcc_ctl_t  ctl_out,
	output logic [NMW-1:0]      quot_x,
	output logic [NMW-1:0]      quot_y
);
	import tcc_pkg::*;

	tcc_ctl_t       ctl_s   [0:NMW];
	logic [NMW-1:0] nx_s    [0:NMW];
	logic [NMW-1:0] ny_s    [0:NMW];
	logic [NMW-1:0] qx_s    [0:NMW];
	logic [NMW-1:0] qy_s    [0:NMW];
	logic [DMW-1:0] rx_s    [0:NMW];
	logic [DMW-1:0] ry_s    [0:NMW];
	logic [DMW-1:0] d_s     [0:NMW];

	assign ctl_s[0] = ctl_in;
	assign nx_s[0]  = num_x;
	assign ny_s[0]  = num_y;
	assign qx_s[0]  = '0;
	assign qy_s[0]  = '0;
	assign rx_s[0]  = '0;
	assign ry_s[0]  = '0;
	assign d_s[0]   = den;

	for (genvar i = 0; i < NMW; i++) begin : g_stage
		logic [DMW:0] tx, ty;
		logic         gx, gy;
		logic [DMW:0] sx, sy;

		always_comb begin
			tx = {rx_s[i], nx_s[i][NMW-1]};
			ty = {ry_s[i], ny_s[i][NMW-1]};
			gx = tx >= {1'b0, d_s[i]};
			gy = ty >= {1'b0, d_s[i]};
			sx = gx ? tx - {1'b0, d_s[i]} : tx;
			sy = gy ? ty - {1'b0, d_s[i]} : ty;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[i+1] <= nx_s[i] << 1;
				ny_s[i+1] <= ny_s[i] << 1;
				qx_s[i+1] <= {qx_s[i][NMW-2:0], gx};
				qy_s[i+1] <= {qy_s[i][NMW-2:0], gy};
				rx_s[i+1] <= sx[DMW-1:0];
				ry_s[i+1] <= sy[DMW-1:0];
				d_s[i+1]  <= d_s[i];
			end
		end
	end

	assign ctl_out = ctl_s[NMW];
	assign quot_x  = qx_s[NMW];
	assign quot_y  = qy_s[NMW];
endmodule

### sim/tb_triangle_circumcenter.sv
// self-checking testbench for the triangle circumcenter block
`timescale 1ns / 1ps
module tb_triangle_circumcenter;
	import tcc_pkg::*;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int LATENCY = 5 + 3 * CB + 4 + FB;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	} triangle_t;

	typedef struct {
		logic signed [OUT_BITS-1:0] cx, cy;
		logic col;
	} center_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, collinear;
	logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy;
	logic signed [OUT_BITS-1:0] center_x, center_y;

	triangle_t pending_tris[$];
	center_t expected_centers[$];
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	bit drain_req = 0;

	triangle_circumcenter #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y), .collinear(collinear)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [OUT_BITS-1:0] fixed_div(
		logic signed [127:0] num, logic signed [127:0] den);
		logic [127:0] nm, dm, q;
		nm = num[127] ? -num : num;
		dm = den[127] ? -den : den;
		q = (nm << FB) / dm;
		if (num[127] != den[127])
			q = -q;
		return q[OUT_BITS-1:0];
	endfunction

	function automatic center_t circumcenter(triangle_t t);
		center_t r;
		logic signed [127:0] x1, y1, x2, y2, x3, y3, d, s1, s2, s3, nx, ny;
		x1 = 128'(t.ax); y1 = 128'(t.ay); x2 = 128'(t.bx);
		y2 = 128'(t.by); x3 = 128'(t.cx); y3 = 128'(t.cy);
		d = 2 * (x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2));
		if (d == 0) begin
			r.cx = OUT_BITS'(-(1 << FB));
			r.cy = OUT_BITS'(-(1 << FB));
			r.col = 1'b1;
			return r;
		end
		s1 = x1 * x1 + y1 * y1;
		s2 = x2 * x2 + y2 * y2;
		s3 = x3 * x3 + y3 * y3;
		nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
		ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
		r.cx = fixed_div(nx, d);
		r.cy = fixed_div(ny, d);
		r.col = 1'b0;
		return r;
	endfunction

	task automatic report(string what, logic [OUT_BITS-1:0] got, logic [OUT_BITS-1:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [CB-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh8000;
		if (r == 1) return 16'sh7fff;
		if (r < 5) return CB'($urandom_range(0, 40) - 20);
		return CB'($urandom);
	endfunction

	task automatic add_tri(int a0, int a1, int b0, int b1, int c0, int c1);
		triangle_t t;
		t.ax = CB'(a0); t.ay = CB'(a1); t.bx = CB'(b0);
		t.by = CB'(b1); t.cx = CB'(c0); t.cy = CB'(c1);
		pending_tris.push_back(t);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{ax, ay, bx, by_coord, cx, cy} <= '0;
			send_gap <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				expected_centers.push_back(circumcenter('{ax, ay, bx, by_coord, cx, cy}));
			if (drain_req && (expected_centers.size() != 0 || in_valid)) begin
				in_valid <= 0;
			end else if (send_gap > 0) begin
				in_valid <= 0;
				send_gap <= send_gap - 1;
			end else if (pending_tris.size() > 0) begin
				triangle_t t;
				t = pending_tris.pop_front();
				in_valid <= 1;
				ax <= t.ax; ay <= t.ay; bx <= t.bx;
				by_coord <= t.by; cx <= t.cx; cy <= t.cy;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver stall and monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			recv_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_centers.size() == 0) begin
					errors++;
					$display("unexpected result at cycle %0d", cycles);
				end else begin
					center_t e;
					e = expected_centers.pop_front();
					if (center_x !== e.cx) report("center_x", center_x, e.cx);
					if (center_y !== e.cy) report("center_y", center_y, e.cy);
					if (collinear !== e.col)
						report("collinear", OUT_BITS'(collinear), OUT_BITS'(e.col));
				end
			end
			if (hold_cycles > 0) begin
				out_stall <= 1;
				hold_cycles <= hold_cycles - 1;
			end else if (recv_gap > 0) begin
				out_stall <= 1;
				recv_gap <= recv_gap - 1;
			end else begin
				out_stall <= 0;
				recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, collinear, degenerate
		add_tri(0, 0, 0, 0, 0, 0);
		add_tri(0, 0, 4, 0, 0, 4);
		add_tri(0, 0, 1, 1, 2, 2);
		add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
		add_tri(32767, 32767, -32768, 32767, 32767, -32768);
		add_tri(-32768, -32768, 32767, 32767, 0, 0);
		add_tri(-32768, 32767, 32767, -32768, 32767, 32767);
		add_tri(1, 0, 0, 1, -1, 0);
		add_tri(3, 7, 3, 7, -5, 2);
		add_tri(-32768, 0, 32767, 0, 0, 1);
		add_tri(0, -32768, 0, 32767, 1, 0);
		add_tri(-1, -1, 1, -1, 0, 3);
		add_tri(32767, 32767, 32767, 32766, 32766, 32767);
		add_tri(-32768, -32768, -32767, -32768, -32768, -32767);
		add_tri(-21845, 21845, 21845, -21845, 1, 2);
		for (int i = 0; i < 700; i++)
			add_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord());
		// long output hold while input keeps coming
		wait (pending_tris.size() < 600);
		@(posedge clk);
		hold_cycles <= 300;
		wait (pending_tris.size() == 0);
		// pause sender until all outstanding results arrive
		drain_req = 1;
		wait (expected_centers.size() == 0 && !in_valid);
		@(posedge clk);
		drain_req = 0;
		for (int i = 0; i < 700; i++) begin
			int k;
			k = $urandom_range(0, 3);
			if (k == 0)
				add_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (k == 1) begin
				int x, y, dx, dy, m;
				x = $urandom_range(0, 2000) - 1000; y = $urandom_range(0, 2000) - 1000;
				dx = $urandom_range(0, 20) - 10; dy = $urandom_range(0, 20) - 10;
				m = $urandom_range(0, 50) - 25;
				add_tri(x, y, x + dx, y + dy, x + m * dx, y + m * dy);
			end else
				add_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord());
		end
		wait (pending_tris.size() == 0 && !in_valid && expected_centers.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
